@@ rtl/cswm_pkg.sv @@
// Shared types, character codes and helpers for the comment-stripped
// whole-word match unit. No dependencies.
`default_nettype none

package cswm_pkg;

	typedef logic [7:0] byte_t;

	// Comment tracking codes
	localparam logic [1:0] MODE_CODE  = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_BLOCK = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_WORD_LENGTH = 2'd0;
	localparam logic [1:0] REG_CHARS_LOW   = 2'd1;
	localparam logic [1:0] REG_CHARS_HIGH  = 2'd2;

	// Character codes
	localparam byte_t CH_SLASH   = 8'h2F;
	localparam byte_t CH_STAR    = 8'h2A;
	localparam byte_t CH_NEWLINE = 8'h0A;
	localparam byte_t CH_SPACE   = 8'h20;
	localparam byte_t CH_UNDER   = 8'h5F;
	localparam byte_t CH_LOW_A   = 8'h61;
	localparam byte_t CH_LOW_Z   = 8'h7A;
	localparam byte_t CH_UP_A    = 8'h41;
	localparam byte_t CH_UP_Z    = 8'h5A;
	localparam byte_t CH_DIGIT_0 = 8'h30;
	localparam byte_t CH_DIGIT_9 = 8'h39;

	// Identifier limit set by the two 64-bit character registers
	localparam int CHAR_REG_COUNT = 16;

	// One cleaned character and the comment mode that follows it
	typedef struct packed {
		byte_t      ch;
		logic [1:0] mode;
	} clean_t;

	function automatic logic is_word_char(byte_t c);
		return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
		       ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
		       ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
		       (c == CH_UNDER);
	endfunction

	// Clean a byte with no pair partner: keep it in code, blank all but newlines in comments
	function automatic clean_t clean_single(byte_t c, logic [1:0] mode);
		clean_t r;
		r.ch   = c;
		r.mode = mode;
		if (mode == MODE_LINE) begin
			if (c == CH_NEWLINE) begin
				r.mode = MODE_CODE;
			end else begin
				r.ch = CH_SPACE;
			end
		end else if (mode == MODE_BLOCK) begin
			if (c != CH_NEWLINE) begin
				r.ch = CH_SPACE;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/comment_stripped_whole_word_match_unit.sv @@
// Top level of the comment-stripped whole-word match unit.
// Depends on cswm_pkg for character codes, mode codes and cleaning helpers.
//
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid, in_ready, text_byte, final_byte | in
// out      | out_valid, out_ready, word_found          | out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item per cycle, unless a final item stalls: an item sits in the input register
// while the comment cleaner, the window shift and three window compares work on it
// in a single pass; a final item's flag then moves on into the result register.
// Reset clears the comment state, lookahead, fill count and found flag, and
// loads the registers with a word length of 1 and zero characters.
// Input stalls only while a final item waits on a full, stalled result register.
`default_nettype none

module comment_stripped_whole_word_match_unit #(
	parameter int MAX_WORD_LEN = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire cswm_pkg::byte_t text_byte,
	input  wire                 final_byte,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                word_found,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [63:0]         cfg_data
);
	import cswm_pkg::*;

	// Usable word length and window geometry
	localparam int LEN_CAP = (MAX_WORD_LEN < CHAR_REG_COUNT) ? MAX_WORD_LEN : CHAR_REG_COUNT;
	localparam int WIN     = LEN_CAP + 1;
	localparam int LEN_W   = $clog2(LEN_CAP + 1);
	localparam int FILL_W  = $clog2(WIN + 1);

	typedef logic [WIN-1:0][7:0]     win_t;
	typedef logic [LEN_CAP-1:0][7:0] rword_t;
	typedef logic [FILL_W-1:0]       fill_t;
	typedef logic [LEN_W-1:0]        len_t;

	// Configuration registers
	logic [4:0]  word_length_q;
	logic [63:0] word_chars_low_q;
	logic [63:0] word_chars_high_q;

	// Input stage
	logic  valid_s1;
	byte_t byte_s1;
	logic  final_s1;

	// Cleaner and search state
	logic [1:0] mode_q;
	byte_t      held_byte_q;
	logic       held_valid_q;
	win_t       win_q;
	fill_t      fill_q;
	logic       found_q;

	// Result register
	logic word_found_q;

	// Derived signals
	len_t                         len_eff;
	logic [CHAR_REG_COUNT-1:0][7:0] chars;
	rword_t                       rword;
	logic                         advance;
	logic                         pair_close;
	logic                         pair_open;
	logic                         pair;
	clean_t                       single_a;
	clean_t                       single_b;
	byte_t                        ch_a;
	byte_t                        ch_b;
	logic [1:0]                   mode_a;
	logic                         push_a;
	logic                         push_b;
	logic                         hit_a;
	logic                         hit_b;
	logic                         hit_end;
	win_t                         win_a;
	win_t                         win_b;
	fill_t                        fill_a;
	fill_t                        fill_b;
	logic                         found_next;

	// Shift a cleaned character into the window, newest at entry 0
	function automatic win_t win_shift(win_t w, byte_t c);
		win_t r;
		r = {w[WIN-2:0], c};
		return r;
	endfunction

	function automatic fill_t fill_step(fill_t f);
		return (f == fill_t'(WIN)) ? f : f + fill_t'(1);
	endfunction

	// True when the word ends at the newest entry with a clean left boundary
	function automatic logic word_here(win_t w, fill_t f);
		logic ok;
		ok = (f >= fill_t'(len_eff));
		for (int p = 0; p < LEN_CAP; p++) begin
			if ((p < int'(len_eff)) && (w[p] != rword[p])) begin
				ok = 1'b0;
			end
		end
		if ((f != fill_t'(len_eff)) && is_word_char(w[len_eff])) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	// Clamp the word length into 1..LEN_CAP
	always_comb begin
		if (word_length_q == 5'd0) begin
			len_eff = len_t'(1);
		end else if (word_length_q > 5'(LEN_CAP)) begin
			len_eff = len_t'(LEN_CAP);
		end else begin
			len_eff = len_t'(word_length_q);
		end
	end

	assign chars = {word_chars_high_q, word_chars_low_q};

	// Reverse the word so that window entry p lines up with rword[p]
	always_comb begin
		int idx;
		for (int p = 0; p < LEN_CAP; p++) begin
			idx = int'(len_eff) - 1 - p;
			if (p < int'(len_eff)) begin
				rword[p] = chars[idx[3:0]];
			end else begin
				rword[p] = '0;
			end
		end
	end

	// Handshakes
	assign advance   = valid_s1 && (!final_s1 || !out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Resolve the held byte against its lookahead, then up to two pushes
	always_comb begin
		pair_close = held_valid_q && (mode_q == MODE_BLOCK) &&
		             (held_byte_q == CH_STAR) && (byte_s1 == CH_SLASH);
		pair_open  = held_valid_q && (mode_q != MODE_LINE) && (mode_q != MODE_BLOCK) &&
		             (held_byte_q == CH_SLASH) &&
		             ((byte_s1 == CH_SLASH) || (byte_s1 == CH_STAR));
		pair       = pair_close || pair_open;

		single_a = clean_single(held_byte_q, mode_q);
		push_a   = held_valid_q;
		ch_a     = pair ? CH_SPACE : single_a.ch;
		if (pair_close) begin
			mode_a = MODE_CODE;
		end else if (pair_open) begin
			mode_a = (byte_s1 == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
		end else if (held_valid_q) begin
			mode_a = single_a.mode;
		end else begin
			mode_a = mode_q;
		end

		// Second space of a pair, or the last byte flushed with no lookahead
		single_b = clean_single(byte_s1, mode_a);
		push_b   = pair || final_s1;
		ch_b     = pair ? CH_SPACE : single_b.ch;

		hit_a  = push_a && word_here(win_q, fill_q) && !is_word_char(ch_a);
		win_a  = push_a ? win_shift(win_q, ch_a) : win_q;
		fill_a = push_a ? fill_step(fill_q) : fill_q;

		hit_b  = push_b && word_here(win_a, fill_a) && !is_word_char(ch_b);
		win_b  = push_b ? win_shift(win_a, ch_b) : win_a;
		fill_b = push_b ? fill_step(fill_a) : fill_a;

		hit_end    = final_s1 && word_here(win_b, fill_b);
		found_next = found_q || hit_a || hit_b || hit_end;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q     <= 5'd1;
			word_chars_low_q  <= '0;
			word_chars_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WORD_LENGTH: word_length_q     <= cfg_data[4:0];
				REG_CHARS_LOW:   word_chars_low_q  <= cfg_data;
				REG_CHARS_HIGH:  word_chars_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: load on accept, drop when advanced with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
	end

	// Cleaner and search state: advance per item, return to idle after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_CODE;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			fill_q       <= '0;
			found_q      <= 1'b0;
		end else if (advance) begin
			if (final_s1) begin
				mode_q       <= MODE_CODE;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
				fill_q       <= '0;
				found_q      <= 1'b0;
			end else begin
				mode_q       <= mode_a;
				held_byte_q  <= pair ? '0 : byte_s1;
				held_valid_q <= !pair;
				fill_q       <= fill_b;
				found_q      <= found_next;
			end
		end
	end

	// Window contents only count below the fill mark
	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_b;
		end
	end

	// Result register: load the flag of a final item, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			word_found_q <= found_next;
		end
	end

	assign word_found = word_found_q;

endmodule

`default_nettype wire

@@ test/comment_stripped_whole_word_match_unit_test.sv @@
// Self-checking testbench for comment_stripped_whole_word_match_unit.
// Holds its own model of comment blanking and whole-word search and checks
// every found flag. Depends on cswm_pkg and the unit's RTL only.
module comment_stripped_whole_word_match_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cswm_pkg::*;

	localparam int MAX_LEN     = 16;
	localparam int WIN_DEPTH   = MAX_LEN + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	byte_t       text_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_ready;
	logic        word_found;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	comment_stripped_whole_word_match_unit #(
		.MAX_WORD_LEN(MAX_LEN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_found (word_found),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Register copies
	logic [4:0]  reg_len;
	logic [63:0] reg_lo;
	logic [63:0] reg_hi;

	// Scanner state
	logic [1:0]  cmt_mode;
	byte_t       pend_byte;
	bit          pend_ok;
	byte_t       clean_win [WIN_DEPTH];
	int          clean_fill;
	bit          hit_seen;

	// Expected found flags, oldest first
	bit          expected_found_q [$];
	bit          want_found;

	// Stimulus and bookkeeping
	byte_t       text_buf [$];
	int          gap_max;
	int          burst_left;
	int          stall_max;
	logic        out_hold;
	int          rx_left;
	bit          rx_stalled;
	int          errors;
	int          results_checked;
	int          items_sent;
	int          texts_sent;
	int          cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- scanner model ----------------

	function automatic bit ident_char(byte_t c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
		       (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || (c == CH_UNDER);
	endfunction

	function automatic int active_len();
		int n;
		n = reg_len;
		if (n == 0) n = 1;
		if (n > MAX_LEN) n = MAX_LEN;
		return n;
	endfunction

	function automatic byte_t target_char(int j);
		return (j < 8) ? reg_lo[8*j +: 8] : reg_hi[8*(j-8) +: 8];
	endfunction

	// True when the word ends at window position off (newest is 0)
	function automatic bit word_ends_at(int off, int len);
		int j;
		for (j = 0; j < len; j++) begin
			if (clean_win[off + len - 1 - j] != target_char(j)) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic clear_scan();
		int k;
		cmt_mode   = MODE_CODE;
		pend_byte  = '0;
		pend_ok    = 1'b0;
		clean_fill = 0;
		hit_seen   = 1'b0;
		for (k = 0; k < WIN_DEPTH; k++) clean_win[k] = '0;
	endtask

	// Shift in one cleaned character and look for a word closed by it
	task automatic push_clean_char(byte_t c);
		int k;
		int len;
		len = active_len();
		for (k = WIN_DEPTH - 1; k > 0; k--) clean_win[k] = clean_win[k-1];
		clean_win[0] = c;
		if (clean_fill < WIN_DEPTH) clean_fill++;
		if (clean_fill >= len + 1 && word_ends_at(1, len) && !ident_char(c) &&
		    (clean_fill == len + 1 || !ident_char(clean_win[len+1])))
			hit_seen = 1'b1;
	endtask

	task automatic check_text_end();
		int len;
		len = active_len();
		if (clean_fill >= len && word_ends_at(0, len) &&
		    (clean_fill == len || !ident_char(clean_win[len])))
			hit_seen = 1'b1;
	endtask

	// Keep a byte in code, blank all but newlines inside comments
	task automatic clean_lone(byte_t h);
		if (cmt_mode == MODE_LINE) begin
			if (h == CH_NEWLINE) begin
				cmt_mode = MODE_CODE;
				push_clean_char(CH_NEWLINE);
			end else begin
				push_clean_char(CH_SPACE);
			end
		end else if (cmt_mode == MODE_BLOCK) begin
			push_clean_char((h == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE);
		end else begin
			push_clean_char(h);
		end
	endtask

	// Resolve the held byte against its follower; taken says the follower was used
	task automatic resolve_pair(input byte_t h, input byte_t b, output bit taken);
		taken = 1'b1;
		if (cmt_mode == MODE_BLOCK && h == CH_STAR && b == CH_SLASH) begin
			push_clean_char(CH_SPACE);
			push_clean_char(CH_SPACE);
			cmt_mode = MODE_CODE;
		end else if (cmt_mode != MODE_LINE && cmt_mode != MODE_BLOCK && h == CH_SLASH &&
		             (b == CH_SLASH || b == CH_STAR)) begin
			push_clean_char(CH_SPACE);
			push_clean_char(CH_SPACE);
			cmt_mode = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
		end else begin
			clean_lone(h);
			taken = 1'b0;
		end
	endtask

	task automatic scan_text_byte(input byte_t b, input bit last,
	                              output bit has_flag, output bit flag);
		bit taken;
		taken    = 1'b0;
		has_flag = 1'b0;
		flag     = 1'b0;
		if (pend_ok) resolve_pair(pend_byte, b, taken);
		if (taken) begin
			pend_ok   = 1'b0;
			pend_byte = '0;
		end else begin
			pend_byte = b;
			pend_ok   = 1'b1;
		end
		// Flush the held byte, close the text and report
		if (last) begin
			if (pend_ok) clean_lone(pend_byte);
			check_text_end();
			has_flag = 1'b1;
			flag     = hit_seen;
			clear_scan();
		end
	endtask

	// ---------------- drivers ----------------

	// Offer one item, hold it until accepted, then maybe open a gap
	task automatic send_text_byte(input byte_t b, input bit last);
		bit has_flag;
		bit flag;
		int gap;
		in_valid   <= 1'b1;
		text_byte  <= b;
		final_byte <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		scan_text_byte(b, last, has_flag, flag);
		if (has_flag) expected_found_q.push_back(flag);
		if (burst_left > 0) begin
			burst_left--;
		end else if (gap_max > 0) begin
			burst_left = $urandom_range(0, 12);
			gap = $urandom_range(1, gap_max);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_buf.size(); i++) send_text_byte(text_buf[i], i == text_buf.size() - 1);
		texts_sent++;
	endtask

	task automatic send_string(input string s);
		int i;
		text_buf.delete();
		for (i = 0; i < s.len(); i++) text_buf.push_back(byte_t'(s[i]));
		send_text();
	endtask

	// Drain all pending flags, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_found_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WORD_LENGTH: reg_len = data[4:0];
			REG_CHARS_LOW:   reg_lo  = data;
			REG_CHARS_HIGH:  reg_hi  = data;
			default: ;
		endcase
	endtask

	task automatic set_word(input logic [63:0] len_word, input logic [63:0] lo,
	                        input logic [63:0] hi);
		settle();
		write_reg(REG_WORD_LENGTH, len_word);
		write_reg(REG_CHARS_LOW, lo);
		write_reg(REG_CHARS_HIGH, hi);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- text generation ----------------

	function automatic byte_t rand_ident_char();
		case ($urandom_range(0, 3))
			0:       return byte_t'($urandom_range(CH_LOW_A, CH_LOW_Z));
			1:       return byte_t'($urandom_range(CH_UP_A, CH_UP_Z));
			2:       return byte_t'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
			default: return CH_UNDER;
		endcase
	endfunction

	function automatic byte_t rand_sep();
		case ($urandom_range(0, 7))
			0, 1:    return CH_SPACE;
			2:       return CH_NEWLINE;
			3:       return 8'h09;
			4:       return 8'h3B;
			5:       return 8'h28;
			6:       return 8'h00;
			default: return 8'h2C;
		endcase
	endfunction

	task automatic append_word();
		int j;
		for (j = 0; j < active_len(); j++) text_buf.push_back(target_char(j));
	endtask

	// Mostly code with the word, comments and separators; some noise and broken pairs
	task automatic build_text();
		int n;
		int k;
		text_buf.delete();
		n = $urandom_range(1, 7);
		repeat (n) begin
			case ($urandom_range(0, 11))
				0, 1, 2: append_word();
				3: begin
					if ($urandom_range(0, 1)) text_buf.push_back(rand_ident_char());
					append_word();
					if ($urandom_range(0, 1)) text_buf.push_back(rand_ident_char());
				end
				4, 5: text_buf.push_back(rand_sep());
				6: begin
					text_buf.push_back(CH_SLASH);
					text_buf.push_back(CH_SLASH);
					k = $urandom_range(0, 3);
					repeat (k) begin
						if ($urandom_range(0, 1)) append_word();
						else text_buf.push_back(rand_sep());
					end
					if ($urandom_range(0, 3) != 0) text_buf.push_back(CH_NEWLINE);
				end
				7: begin
					text_buf.push_back(CH_SLASH);
					text_buf.push_back(CH_STAR);
					k = $urandom_range(0, 3);
					repeat (k) begin
						case ($urandom_range(0, 2))
							0:       append_word();
							1:       text_buf.push_back(CH_NEWLINE);
							default: text_buf.push_back(byte_t'($urandom_range(0, 255)));
						endcase
					end
					if ($urandom_range(0, 3) != 0) begin
						text_buf.push_back(CH_STAR);
						text_buf.push_back(CH_SLASH);
					end
				end
				8: begin
					k = $urandom_range(1, 4);
					repeat (k) text_buf.push_back(byte_t'($urandom_range(0, 255)));
				end
				9: begin
					case ($urandom_range(0, 3))
						0: text_buf.push_back(CH_SLASH);
						1: text_buf.push_back(CH_STAR);
						2: begin
							text_buf.push_back(CH_STAR);
							text_buf.push_back(CH_SLASH);
						end
						default: begin
							text_buf.push_back(CH_SLASH);
							text_buf.push_back(CH_STAR);
							text_buf.push_back(CH_SLASH);
						end
					endcase
				end
				10: begin
					k = $urandom_range(1, 4);
					repeat (k) text_buf.push_back(rand_ident_char());
				end
				default: text_buf.push_back(CH_NEWLINE);
			endcase
		end
	endtask

	// ---------------- tests ----------------

	// Reset word, zero length and the ignored upper bits of the length write
	task automatic test_register_limits();
		text_buf.delete();
		text_buf.push_back(8'h00);
		send_text();
		set_word(64'hFFFF_FFFF_FFFF_FFE0, '1, '1);
		text_buf.delete();
		text_buf.push_back(8'hFF);
		send_text();
	endtask

	// Short texts covering each comment form and the end-of-text cases
	task automatic test_comment_cases();
		set_word(64'd2, 64'h6261, 64'd0);
		send_string("ab");
		send_string("/*ab*/");
		send_string("//\nab");
		send_string("ab/");
		send_string("_ab");
	endtask

	task automatic test_random_texts();
		int ph;
		int j;
		int n;
		int len_raw;
		int start;
		logic [63:0] len_word;
		logic [63:0] lo;
		logic [63:0] hi;
		byte_t c;
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       len_raw = 1;
				1:       len_raw = 16;
				2:       len_raw = 31;
				3:       len_raw = 0;
				default: len_raw = $urandom_range(2, 8);
			endcase
			n = (len_raw == 0) ? 1 : ((len_raw > MAX_LEN) ? MAX_LEN : len_raw);
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			for (j = 0; j < n; j++) begin
				c = ($urandom_range(0, 9) == 0) ? byte_t'($urandom_range(0, 255)) : rand_ident_char();
				if (j < 8) lo[8*j +: 8] = c;
				else hi[8*(j-8) +: 8] = c;
			end
			len_word = {$urandom, $urandom};
			len_word[4:0] = len_raw[4:0];
			set_word(len_word, lo, hi);
			// Alternate between no idling, light and heavy idling
			case (ph % 3)
				0: begin
					gap_max   = 0;
					stall_max = 0;
				end
				1: begin
					gap_max   = 2;
					stall_max = 4;
				end
				default: begin
					gap_max   = 8;
					stall_max = 20;
				end
			endcase
			start = items_sent;
			while (items_sent - start < 190) begin
				build_text();
				send_text();
			end
		end
	endtask

	// Hold off the result side while short texts keep coming
	task automatic test_output_backpressure();
		int k;
		set_word(64'd1, {56'd0, rand_ident_char()}, 64'd0);
		gap_max   = 0;
		stall_max = 0;
		fork
			begin
				out_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_hold <= 1'b0;
			end
			begin
				for (k = 0; k < 40; k++) begin
					text_buf.delete();
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 2))
							0:       text_buf.push_back(target_char(0));
							1:       text_buf.push_back(rand_ident_char());
							default: text_buf.push_back(CH_SPACE);
						endcase
					end
					send_text();
				end
			end
		join
	endtask

	// ---------------- result side ----------------

	// Ready and stalled stretches of random length
	always @(posedge clk) begin
		if (rx_left > 0) begin
			rx_left--;
		end else if (stall_max == 0) begin
			rx_stalled = 1'b0;
		end else begin
			rx_stalled = !rx_stalled;
			rx_left = rx_stalled ? $urandom_range(1, stall_max) : $urandom_range(1, 16);
		end
		out_ready <= !rx_stalled && !out_hold;
	end

	// Compare each accepted result with the oldest expected flag
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_found_q.size() == 0) begin
				$display("%0t: result with none expected, word_found=%0b", $time, word_found);
				errors++;
			end else begin
				want_found = expected_found_q.pop_front();
				results_checked++;
				if (want_found !== word_found) begin
					$display("%0t: word_found mismatch, expected %0b, actual %0b",
					         $time, want_found, word_found);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) cycle_count++;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d flags outstanding",
		         $time, cycle_count, expected_found_q.size());
		$display("Verification failed");
		$finish;
	end

	// ---------------- sequence ----------------

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		text_byte  = '0;
		final_byte = 1'b0;
		out_ready  = 1'b0;
		out_hold   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_WORD_LENGTH;
		cfg_data   = '0;
		reg_len    = 5'd1;
		reg_lo     = '0;
		reg_hi     = '0;
		gap_max    = 0;
		burst_left = 0;
		stall_max  = 0;
		rx_left    = 0;
		rx_stalled = 1'b0;
		errors          = 0;
		results_checked = 0;
		items_sent      = 0;
		texts_sent      = 0;
		cycle_count     = 0;
		clear_scan();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_register_limits();
		test_comment_cases();
		test_random_texts();
		test_output_backpressure();

		settle();
		repeat (20) @(posedge clk);
		$display("Sent %0d texts in %0d bytes; checked %0d found flags.",
		         texts_sent, items_sent, results_checked);
		$display("Word lengths 0, 1, 16, 31 and short random ones, comments, lone delimiters and stalls exercised.");
		if (errors == 0 && expected_found_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
